[sv/gcd_lcm_unit_core_assert.svh]
// ---------------------------------------------------------------------------
// gcd_lcm_unit_core assertion macros
// Shared property shapes for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_CORE_ASSERT_SVH
`define GCD_LCM_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define GLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd_lcm_unit_core: same-cycle check failed");

// next-cycle implication
`define GLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd_lcm_unit_core: next-cycle check failed");

`endif

[sv/glu_pkg.sv]
// ---------------------------------------------------------------------------
// glu_pkg
// Types shared by the gcd/lcm unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package glu_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_DIV,
        S_Q_DIV,
        S_MUL,
        S_DONE
    } t_state;

endpackage

[sv/gcd_lcm_unit_core.sv]
// ---------------------------------------------------------------------------
// gcd_lcm_unit_core
// Euclid gcd and saturating lcm on one shared add/subtract unit.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start / busy       i_operand_a, i_operand_b
//  result    o_valid (strobe)   o_gcd_value, o_lcm_value, o_lcm_overflow,
//                               o_operand_invalid
//
//  One beat runs the Euclid remainder steps, then the quotient a / gcd,
//  then the product; every remainder, the quotient and the product run
//  one bit per cycle through the shared adder. A zero operand skips
//  straight from accept to the result strobe.
//  Synchronous active-low reset returns the sequencer to idle.
//  busy stays high from accept through the result strobe; results cannot
//  be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_unit_core #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_gcd_value,
    output logic [DATA_WIDTH-1:0] o_lcm_value,
    output logic                  o_lcm_overflow,
    output logic                  o_operand_invalid
);
    import glu_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int AW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    t_state          r_state, n_state;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W-1:0]    r_dvs, n_dvs;
    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_quo, n_quo;
    logic [W-1:0]    r_gcd, n_gcd;
    logic [AW-1:0]   r_acc, n_acc;
    logic [AW-1:0]   r_mcand, n_mcand;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_inv, n_inv;

    logic [W:0]      shifted;
    logic [AW-1:0]   op_x, op_y, sum;
    logic            cin;
    logic            neg;
    logic [W-1:0]    step_rem;
    logic [W-1:0]    step_quo;
    logic            last;

    // shared adder
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        if (r_state == S_MUL) begin
            op_x = r_acc;
            op_y = r_quo[0] ? r_mcand : '0;
            cin  = 1'b0;
        end else begin
            op_x = {{(AW-W-1){1'b0}}, shifted};
            op_y = ~{{W{1'b0}}, r_dvs};
            cin  = 1'b1;
        end
        sum      = op_x + op_y + {{(AW-1){1'b0}}, cin};
        neg      = sum[AW-1];
        step_rem = neg ? shifted[W-1:0] : sum[W-1:0];
        step_quo = {r_quo[W-2:0], ~neg};
        last     = (r_cnt == CW'(W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_inv   <= n_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_dvs   <= n_dvs;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_gcd   <= n_gcd;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_gcd   = r_gcd;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_cnt   = r_cnt;
        n_inv   = r_inv;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a   = i_operand_a;
                    n_b   = i_operand_b;
                    n_rem = '0;
                    n_cnt = '0;
                    n_gcd = '0;
                    n_acc = '0;
                    if (i_operand_a == '0 || i_operand_b == '0) begin
                        n_inv   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_inv   = 1'b0;
                        n_state = S_GCD_DIV;
                        if (i_operand_a > i_operand_b) begin
                            n_quo = i_operand_a;
                            n_dvs = i_operand_b;
                        end else begin
                            n_quo = i_operand_b;
                            n_dvs = i_operand_a;
                        end
                    end
                end
            end
            S_GCD_DIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (step_rem == '0) begin
                        n_gcd   = r_dvs;
                        n_quo   = r_a;
                        n_state = S_Q_DIV;
                    end else begin
                        n_quo = r_dvs;
                        n_dvs = step_rem;
                    end
                end
            end
            S_Q_DIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_mcand = {{W{1'b0}}, r_b};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc   = sum;
                n_quo   = {1'b0, r_quo[W-1:1]};
                n_mcand = {r_mcand[AW-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (last) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_DONE);
    assign o_gcd_value       = r_gcd;
    assign o_lcm_overflow    = |r_acc[AW-1:W];
    assign o_lcm_value       = o_lcm_overflow ? {W{1'b1}} : r_acc[W-1:0];
    assign o_operand_invalid = r_inv;

endmodule

[sv/glu_chk.sv]
// ---------------------------------------------------------------------------
// glu_chk
// Port-level checker for gcd_lcm_unit_core, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_unit_core_assert.svh"

module glu_chk #(
    parameter int DATA_WIDTH = 31
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DATA_WIDTH-1:0] o_gcd_value,
    input logic [DATA_WIDTH-1:0] o_lcm_value,
    input logic                  o_lcm_overflow,
    input logic                  o_operand_invalid
);

    logic zero_fields;
    logic result_nonzero;

    assign zero_fields    = (o_gcd_value == '0) && (o_lcm_value == '0) && !o_lcm_overflow;
    assign result_nonzero = (o_gcd_value != '0) && (o_lcm_value != '0);

    `GLU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `GLU_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `GLU_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid && !busy)
    `GLU_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_valid && o_operand_invalid, zero_fields)
    `GLU_ASSERT_NOW(a_gcd_nonzero, i_clk, i_rst_n, o_valid && !o_operand_invalid, result_nonzero)

endmodule

bind gcd_lcm_unit_core glu_chk #(
    .DATA_WIDTH(DATA_WIDTH)
) u_glu_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_gcd_value       (o_gcd_value),
    .o_lcm_value       (o_lcm_value),
    .o_lcm_overflow    (o_lcm_overflow),
    .o_operand_invalid (o_operand_invalid)
);
